### sv/point_rotate_about_axis_macros.svh
// Assertion helpers used by the point rotation RTL.
`ifndef POINT_ROTATE_ABOUT_AXIS_MACROS_SVH
`define POINT_ROTATE_ABOUT_AXIS_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pra: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pra: assertion failed");

`endif

### sv/pra_pkg.sv
package pra_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } pra_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
  } pra_out_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd5;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;

  localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
    32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
    32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
    32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D
  };

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RUN,
    CS_DONE
  } cs_e;

endpackage

### sv/point_rotate_about_axis.sv
// Point rotation about a coordinate axis through a programmable centre.
// Input channel: in_valid_i / in_stall_o carry one word of three Q16.16
// coordinates. Output channel: out_valid_o / out_stall_i carry one word of
// three saturated Q16.16 coordinates. A word moves when valid is high and
// stall is low at a rising edge of clk_i.
// Pipeline: four registered stages (select and subtract, multiply, sum and
// round, centre add and saturate); one word per cycle sustained while the
// output is not stalled and the sine/cosine sequencer is idle.
// Configuration: write cfg_data_i to register cfg_idx_i with cfg_we_i
// (0 axis, 1 angle, 2 reverse, 3..5 centre x/y/z), only with the pipeline
// empty. A write to angle or reverse starts the sine/cosine sequencer
// (load, CORDIC steps at one per cycle, quadrant restore), during which
// in_stall_o is held high.
// Reset (rst_ni low, asynchronous) zeroes configuration, sequencer state and
// valid bits: zero angle, so points pass unchanged; the pipeline empties.
// A stall at the output holds the last stage; earlier stages keep filling
// bubbles; in_stall_o rises once stage one is blocked or the sequencer busy.
module point_rotate_about_axis
  import pra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pra_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pra_out_t             out_data_o
);

`include "point_rotate_about_axis_macros.svh"

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]         axis_q;
  logic [15:0]        angle_q;
  logic               rev_q;
  logic signed [31:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= '0;
      angle_q <= '0;
      rev_q   <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AXIS:     axis_q  <= cfg_data_i[1:0];
        CFG_ANGLE:    angle_q <= cfg_data_i[15:0];
        CFG_REVERSE:  rev_q   <= cfg_data_i[0];
        CFG_CENTER_X: cx_q    <= cfg_data_i;
        CFG_CENTER_Y: cy_q    <= cfg_data_i;
        CFG_CENTER_Z: cz_q    <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // A write to angle or reverse invalidates the stored sine and cosine.
  logic restart;
  assign restart = cfg_we_i && (cfg_idx_i == CFG_ANGLE || cfg_idx_i == CFG_REVERSE);

  // Effective angle, quadrant and residual in [-1/8, 1/8) turn.
  logic [15:0] angle_eff, quad_sum, resid;
  logic [1:0]  quad;
  assign angle_eff = rev_q ? (16'd0 - angle_q) : angle_q;
  assign quad_sum  = angle_eff + 16'h2000;
  assign quad      = quad_sum[15:14];
  assign resid     = angle_eff - {quad, 14'd0};

  // ---------------------------------------------------------------------
  // Sine/cosine sequencer: one CORDIC micro-rotation per cycle
  // ---------------------------------------------------------------------
  cs_e                cs_q, cs_d;
  logic [3:0]         step_q, step_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]         q_q, q_d;
  logic signed [31:0] cos_q, cos_d, sin_q, sin_d;
  logic signed [31:0] sh_x, sh_y;

  assign sh_x = x_q >>> step_q;
  assign sh_y = y_q >>> step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= CS_IDLE;
      step_q <= '0;
    end else begin
      cs_q   <= cs_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    q_q   <= q_d;
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  always_comb begin
    cs_d   = cs_q;
    step_d = step_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    q_d    = q_q;
    cos_d  = cos_q;
    sin_d  = sin_q;
    unique case (cs_q)
      CS_IDLE: ;
      CS_LOAD: begin
        x_d    = CORDIC_GAIN;
        y_d    = '0;
        z_d    = {resid, 16'd0};
        q_d    = quad;
        step_d = '0;
        cs_d   = CS_RUN;
      end
      CS_RUN: begin
        if (!z_q[31]) begin
          x_d = x_q - sh_y;
          y_d = y_q + sh_x;
          z_d = z_q - ATAN_TAB[step_q];
        end else begin
          x_d = x_q + sh_y;
          y_d = y_q - sh_x;
          z_d = z_q + ATAN_TAB[step_q];
        end
        if (step_q == 4'(CORDIC_STEPS - 1)) begin
          cs_d = CS_DONE;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      CS_DONE: begin
        // restore the quadrant by exact swaps and negations
        case (q_q)
          2'd0:    begin cos_d = x_q;  sin_d = y_q;  end
          2'd1:    begin cos_d = -y_q; sin_d = x_q;  end
          2'd2:    begin cos_d = -x_q; sin_d = -y_q; end
          default: begin cos_d = y_q;  sin_d = -x_q; end
        endcase
        cs_d = CS_IDLE;
      end
      default: cs_d = CS_IDLE;
    endcase
    if (restart) begin
      cs_d = CS_LOAD;
    end
  end

  // Zero angle and the no-axis code use exact unit coefficients, so the
  // point comes back bit for bit.
  logic               ident;
  logic signed [31:0] cos_use, sin_use;
  assign ident   = (angle_eff == 16'd0) || (axis_q == AXIS_NONE);
  assign cos_use = ident ? ONE_Q30 : cos_q;
  assign sin_use = ident ? 32'sd0 : sin_q;

  // ---------------------------------------------------------------------
  // Pipeline handshake: a stage advances when empty or when the next one
  // advances.
  // ---------------------------------------------------------------------
  logic [3:0] v_q;
  logic [3:0] en;

  assign en[3] = !v_q[3] || !out_stall_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  assign in_stall_o  = !en[0] || (cs_q != CS_IDLE);
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i && (cs_q == CS_IDLE);
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: pick the coordinate pair and subtract the centre (33 bits)
  // ---------------------------------------------------------------------
  logic signed [31:0] p1, p2, c1, c2, pt;

  always_comb begin
    unique case (axis_q)
      AXIS_X: begin
        p1 = in_data_i.point_y; p2 = in_data_i.point_z;
        c1 = cy_q;              c2 = cz_q;
        pt = in_data_i.point_x;
      end
      AXIS_Y: begin
        p1 = in_data_i.point_x; p2 = in_data_i.point_z;
        c1 = cx_q;              c2 = cz_q;
        pt = in_data_i.point_y;
      end
      default: begin
        // Z axis; the no-axis code shares this pair with unit coefficients
        p1 = in_data_i.point_x; p2 = in_data_i.point_y;
        c1 = cx_q;              c2 = cy_q;
        pt = in_data_i.point_z;
      end
    endcase
  end

  logic signed [32:0] s1_d1_q, s1_d2_q;
  logic signed [31:0] s1_c1_q, s1_c2_q, s1_pt_q, s1_cos_q, s1_sin_q;
  logic [1:0]         s1_ax_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_d1_q  <= {p1[31], p1} - {c1[31], c1};
      s1_d2_q  <= {p2[31], p2} - {c2[31], c2};
      s1_c1_q  <= c1;
      s1_c2_q  <= c2;
      s1_pt_q  <= pt;
      s1_cos_q <= cos_use;
      s1_sin_q <= sin_use;
      s1_ax_q  <= axis_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: four 33 x 32 products
  // ---------------------------------------------------------------------
  logic signed [64:0] s2_cd1_q, s2_sd2_q, s2_cd2_q, s2_sd1_q;
  logic signed [31:0] s2_c1_q, s2_c2_q, s2_pt_q;
  logic [1:0]         s2_ax_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_cd1_q <= s1_d1_q * s1_cos_q;
      s2_sd2_q <= s1_d2_q * s1_sin_q;
      s2_cd2_q <= s1_d2_q * s1_cos_q;
      s2_sd1_q <= s1_d1_q * s1_sin_q;
      s2_c1_q  <= s1_c1_q;
      s2_c2_q  <= s1_c2_q;
      s2_pt_q  <= s1_pt_q;
      s2_ax_q  <= s1_ax_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: combine, round to nearest and drop the Q30 fraction
  // ---------------------------------------------------------------------
  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

  logic signed [65:0] sum_a, sum_b;
  assign sum_a = {s2_cd1_q[64], s2_cd1_q} + {s2_sd2_q[64], s2_sd2_q} + HALF_Q30;
  assign sum_b = {s2_cd2_q[64], s2_cd2_q} - {s2_sd1_q[64], s2_sd1_q} + HALF_Q30;

  logic signed [35:0] s3_r1_q, s3_r2_q;
  logic signed [31:0] s3_c1_q, s3_c2_q, s3_pt_q;
  logic [1:0]         s3_ax_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_r1_q <= sum_a[65:30];
      s3_r2_q <= sum_b[65:30];
      s3_c1_q <= s2_c1_q;
      s3_c2_q <= s2_c2_q;
      s3_pt_q <= s2_pt_q;
      s3_ax_q <= s2_ax_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: add the centre back, saturate, place in the output word
  // ---------------------------------------------------------------------
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
      return v[31:0];
    end else if (v[36]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  logic signed [36:0] n1, n2;
  logic signed [31:0] q1, q2;
  assign n1 = {{5{s3_c1_q[31]}}, s3_c1_q} + {s3_r1_q[35], s3_r1_q};
  assign n2 = {{5{s3_c2_q[31]}}, s3_c2_q} + {s3_r2_q[35], s3_r2_q};
  assign q1 = sat32(n1);
  assign q2 = sat32(n2);

  pra_out_t out_q, out_d;

  always_comb begin
    unique case (s3_ax_q)
      AXIS_X: begin
        out_d.rotated_x = s3_pt_q; out_d.rotated_y = q1; out_d.rotated_z = q2;
      end
      AXIS_Y: begin
        out_d.rotated_x = q1; out_d.rotated_y = s3_pt_q; out_d.rotated_z = q2;
      end
      default: begin
        out_d.rotated_x = q1; out_d.rotated_y = q2; out_d.rotated_z = s3_pt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PRA_ASSERT_NEXT(a_restart_loads, clk_i, rst_ni, restart, cs_q == CS_LOAD)
  `PRA_ASSERT_NEXT(a_load_runs, clk_i, rst_ni,
                   cs_q == CS_LOAD && !restart, cs_q == CS_RUN && step_q == 4'd0)
  `PRA_ASSERT_NOW(a_done_after_last_step, clk_i, rst_ni,
                  cs_q == CS_DONE, step_q == 4'(CORDIC_STEPS - 1))
  `PRA_ASSERT_NEXT(a_accept_fills_stage1, clk_i, rst_ni,
                   in_valid_i && !in_stall_o, v_q[0])

endmodule

### sim/point_rotation_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both word channels, predicts each
// rotated point on input acceptance and compares it on output acceptance.
module point_rotation_checker
  import pra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  pra_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  pra_out_t             out_data_i,
  output int                   outstanding_o,
  output int                   mismatches_o
);

  // Arctangents of 2^-i, 2^32 per full turn.
  localparam longint ARCTAN [16] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
  };
  localparam longint START_X  = 64'd652032874;
  localparam longint HALF_Q30 = 64'd536870912;

  logic [1:0]  set_axis;
  logic [15:0] set_angle;
  logic        set_reverse;
  longint      set_cx, set_cy, set_cz;
  pra_out_t    rotated_due [$];
  int          errs = 0;

  // Cosine and sine in Q2.30: fold to the nearest quarter turn, then CORDIC.
  function automatic void sine_cosine(input logic [15:0] ang, output longint co,
                                      output longint si);
    logic [16:0] shifted;
    logic [1:0]  quad;
    longint      r, x, y, z, nx;
    shifted = {1'b0, ang} + 17'h2000;
    quad = shifted[15:14];
    r = longint'(ang) - longint'(quad) * 16384;
    if (r >= 32768) r -= 65536;
    z = r * 65536;
    x = START_X;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN[i];
      end
      x = nx;
    end
    case (quad)
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Differences are kept at full width; only the sums saturate.
  function automatic void turn_pair(inout longint p1, inout longint p2,
                                    input longint c1, input longint c2,
                                    input longint co, input longint si);
    longint d1, d2, a, b;
    d1 = p1 - c1;
    d2 = p2 - c2;
    a = co * d1 + si * d2;
    b = co * d2 - si * d1;
    p1 = clamp32(c1 + ((a + HALF_Q30) >>> 30));
    p2 = clamp32(c2 + ((b + HALF_Q30) >>> 30));
  endfunction

  function automatic pra_out_t rotated_point(input pra_in_t pt);
    logic [15:0] turn;
    longint      co, si, px, py, pz;
    pra_out_t    res;
    px = longint'($signed(pt.point_x));
    py = longint'($signed(pt.point_y));
    pz = longint'($signed(pt.point_z));
    turn = set_reverse ? 16'd0 - set_angle : set_angle;
    if (turn != 16'd0 && set_axis != AXIS_NONE) begin
      sine_cosine(turn, co, si);
      case (set_axis)
        AXIS_X:  turn_pair(py, pz, set_cy, set_cz, co, si);
        AXIS_Y:  turn_pair(px, pz, set_cx, set_cz, co, si);
        default: turn_pair(px, py, set_cx, set_cy, co, si);
      endcase
    end
    res.rotated_x = px[31:0];
    res.rotated_y = py[31:0];
    res.rotated_z = pz[31:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pra_out_t want;
    if (!rst_ni) begin
      set_axis    = AXIS_X;
      set_angle   = '0;
      set_reverse = 1'b0;
      set_cx      = 0;
      set_cy      = 0;
      set_cz      = 0;
      rotated_due.delete();
      outstanding_o <= 0;
      mismatches_o  <= errs;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AXIS:     set_axis    = cfg_data_i[1:0];
          CFG_ANGLE:    set_angle   = cfg_data_i[15:0];
          CFG_REVERSE:  set_reverse = cfg_data_i[0];
          CFG_CENTER_X: set_cx      = longint'($signed(cfg_data_i));
          CFG_CENTER_Y: set_cy      = longint'($signed(cfg_data_i));
          CFG_CENTER_Z: set_cz      = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rotated_due.push_back(rotated_point(in_data_i));
      if (out_valid_i === 1'b1 && !out_stall_i) begin
        if (rotated_due.size() == 0) begin
          errs++;
          $display("%0t: word expected none, got %h", $time, out_data_i);
        end else begin
          want = rotated_due.pop_front();
          check_field("rotated_x", want.rotated_x, out_data_i.rotated_x);
          check_field("rotated_y", want.rotated_y, out_data_i.rotated_y);
          check_field("rotated_z", want.rotated_z, out_data_i.rotated_z);
        end
      end
      outstanding_o <= rotated_due.size();
      mismatches_o  <= errs;
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

// Point rotation bench: the top drives configuration and point words and
// stalls the result channel; the checker beside the block predicts and
// compares every rotated word.
module testbench;
  import pra_pkg::*;

  localparam int IDLE_LIMIT      = 4000; // cycles without any transfer
  localparam int HOLD_CYCLES     = 300;  // long output back-pressure
  localparam int RANDOM_PHASES   = 22;
  localparam int WORDS_PER_PHASE = 50;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_AXIS;
  logic [31:0]          cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  pra_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pra_out_t             out_data;

  int outstanding;
  int mismatches;
  int idle_cycles = 0;
  bit steady      = 1'b0; // sender offers back-to-back words
  bit squeeze_req = 1'b0; // ask the receiver for its long hold-off

  point_rotate_about_axis dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  point_rotation_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort when nothing moves for too long: a lost word or a hung handshake.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[point_rotate_about_axis] ERROR");
      $finish;
    end
  end

  // Offer one point word after a random gap (none when steady); hold it until taken.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int unsigned gap;
    pra_in_t     pt;
    pt.point_x = x;
    pt.point_y = y;
    pt.point_z = z;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for the pipeline to drain before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write every register on consecutive edges, keeping the enable high.
  task automatic load_setup(input logic [1:0] axis, input logic [15:0] angle,
                            input logic rev, input logic [31:0] cx,
                            input logic [31:0] cy, input logic [31:0] cz);
    logic [CFG_IDX_W-1:0] slot [6];
    logic [31:0]          value [6];
    slot  = '{CFG_AXIS, CFG_ANGLE, CFG_REVERSE, CFG_CENTER_X, CFG_CENTER_Y,
              CFG_CENTER_Z};
    value = '{32'(axis), 32'(angle), 32'(rev), cx, cy, cz};
    foreach (slot[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= slot[i];
      cfg_data <= value[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly small coordinates or ones close to the centre, some full range.
  function automatic logic [31:0] pick_coord(input logic [31:0] near);
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return pick_extreme();
      3, 4: return near + $urandom_range(0, 32'h10_0000) - 32'h8_0000;
      default: return $urandom_range(0, 32'h40_0000) - 32'h20_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_centre();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return $urandom;
      2: return pick_extreme();
      default: return $urandom_range(0, 32'h100_0000) - 32'h80_0000;
    endcase
  endfunction

  // Quadrant edges and the ends of the range, else anything.
  function automatic logic [15:0] pick_angle();
    logic [15:0] edges [10];
    edges = '{16'h0000, 16'h0001, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
              16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  // Result side: stall a random while per word, once hold off for a long
  // stretch so the block backs up and stalls its input.
  initial begin : receiver
    int unsigned hold;
    int unsigned words;
    bit          quiet;
    bit          squeezed;
    words    = 0;
    quiet    = 1'b0;
    squeezed = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (words % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = quiet ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      words++;
    end
  end

  initial begin : stimulus
    logic [1:0]  axis;
    logic [31:0] cx, cy, cz;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset value: zero angle, points pass through.
    send_point(Q_MAX, Q_MIN, '0);
    send_point('1, 32'd1, Q_MIN);

    // Eighth turn about X through the origin, saturating corners.
    settle();
    load_setup(AXIS_X, 16'h2000, 1'b0, '0, '0, '0);
    send_point(Q_MAX, Q_MAX, Q_MIN);
    send_point(Q_ONE, Q_ONE, Q_ONE);

    // Reversed quarter turn about Y with far-apart centre: wide differences.
    settle();
    load_setup(AXIS_Y, 16'h4000, 1'b1, Q_MIN, '0, Q_MAX);
    send_point(Q_MAX, 32'd5, Q_MIN);
    send_point(Q_MIN, '1, Q_MAX);

    // Smallest step short of a full turn about Z.
    settle();
    load_setup(AXIS_Z, 16'hFFFF, 1'b0, Q_ONE, Q_MAX, '0);
    send_point(32'd1, Q_MIN, Q_MAX);
    send_point(32'h0003_0000, -32'sh2_0000, 32'd7);

    // Axis code three: no rotation whatever the angle.
    settle();
    load_setup(AXIS_NONE, 16'h1234, 1'b1, Q_MAX, Q_MIN, Q_ONE);
    send_point(Q_MAX, Q_MIN, 32'd1234);
    send_point($urandom, $urandom, $urandom);

    // Reversed half turn about Z.
    settle();
    load_setup(AXIS_Z, 16'h8000, 1'b1, -32'sh8000, 32'h8000, '0);
    send_point(Q_MIN, Q_MAX, '1);
    send_point(32'h0001_8000, -32'sh0002_4000, Q_ONE);

    // An eighth short of a full turn, on the quadrant fold.
    settle();
    load_setup(AXIS_X, 16'hE000, 1'b0, '0, Q_ONE, -32'sh1_0000);
    send_point('0, Q_MAX, Q_MIN);
    send_point(32'd3, 32'h0004_0000, 32'h0002_0000);

    // Zero angle with reverse set: still a pass-through.
    settle();
    load_setup(AXIS_Y, 16'h0000, 1'b1, Q_MAX, Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MIN, Q_MIN);
    send_point(Q_MAX, '0, Q_ONE);

    // One count below the quadrant boundary, centre at the extremes.
    settle();
    load_setup(AXIS_X, 16'h1FFF, 1'b0, Q_MAX, Q_MIN, Q_MAX);
    send_point('0, Q_MAX, '0);
    send_point('1, '0, Q_MIN);

    // Random settings, points mostly small or around the centre.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      axis = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
      cx = pick_centre();
      cy = pick_centre();
      cz = pick_centre();
      load_setup(axis, pick_angle(), 1'($urandom_range(0, 1)), cx, cy, cz);
      steady = ($urandom_range(0, 3) == 0);
      if (ph == 3) begin
        steady      = 1'b1;
        squeeze_req = 1'b1;
      end
      repeat (WORDS_PER_PHASE) send_point(pick_coord(cx), pick_coord(cy), pick_coord(cz));
    end

    settle();
    repeat (12) @(posedge clk);
    if (mismatches == 0)
      $display("[point_rotate_about_axis] OK");
    else
      $display("[point_rotate_about_axis] ERROR");
    $finish;
  end

endmodule
